// File: hdl/fsa_pkg.sv
package fsa_pkg;

  localparam int ADDR_W = 21;
  localparam int LEN_W = 22;
  localparam int CNT_OUT_W = 6;
  localparam int DEF_MAX_SEGMENTS = 32;

  localparam logic [ADDR_W-1:0] POOL_BASE_RST = 21'h154000;
  localparam logic [LEN_W-1:0] POOL_SIZE_RST = 22'h0AC000;
  localparam logic [LEN_W-1:0] LEN_MAX = 22'h3FFFFF;

  // Command codes
  localparam logic [1:0] CMD_ALLOC = 2'd0;
  localparam logic [1:0] CMD_FREE = 2'd1;
  localparam logic [1:0] CMD_INIT = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NOFIT = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  // Configuration register indexes
  localparam logic CFG_POOL_BASE = 1'b0;
  localparam logic CFG_POOL_SIZE = 1'b1;

  typedef struct packed {
    logic [1:0] cmd;
    logic [LEN_W-1:0] req_length;
    logic [ADDR_W-1:0] free_address;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [ADDR_W-1:0] grant_address;
    logic [LEN_W-1:0] total_free;
    logic [LEN_W-1:0] largest_free;
    logic [CNT_OUT_W-1:0] segment_count;
  } rsp_t;

  // Saturating length add
  function automatic logic [LEN_W-1:0] sat_add(input logic [LEN_W-1:0] a,
                                               input logic [LEN_W-1:0] b);
    logic [LEN_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    sat_add = s[LEN_W] ? LEN_MAX : s[LEN_W-1:0];
  endfunction

endpackage

// File: hdl/free_segment_allocator.sv
// Init, unused commands, zero-length frees and early-refused allocations go from accept straight
// to the result. Others: accept, scan, shift to open or close a slot, merge check, shift after a
// merge, recount and result, one table entry per cycle through the segment memory port.
// One command is in work at a time; the next word is taken while a result waits.
// Reset empties the table, clears the totals and loads the pool registers; memory is kept.
module free_segment_allocator
  import fsa_pkg::*;
#(
  parameter int MAX_SEGMENTS = DEF_MAX_SEGMENTS
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic cfg_index,
  input  logic [LEN_W-1:0] cfg_data
);

  localparam int IDX_W = $clog2(MAX_SEGMENTS);
  localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SEGMENTS);

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_DECIDE, S_SHIFT, S_PUT, S_MRD, S_MWAIT, S_SUM, S_FIN
  } state_t;

  state_t state;
  logic [ADDR_W-1:0] pool_base;
  logic [LEN_W-1:0] pool_size;
  logic [CNT_W-1:0] used;
  logic [LEN_W-1:0] free_sum, free_max;
  logic [1:0] cmd_q, status_q;
  logic [LEN_W-1:0] len_q;
  logic [ADDR_W-1:0] addr_q, grant_q;
  logic [CNT_W-1:0] iss;

  // scan results
  logic ex_f, end_f, ins_f;
  logic [IDX_W-1:0] ex_idx, big_idx, end_idx, ins_idx;
  logic [ADDR_W-1:0] ex_start, big_start, end_start;
  logic [LEN_W-1:0] big_len, end_len;

  // touched segment and shift engine
  logic [IDX_W-1:0] cur;
  logic [ADDR_W-1:0] cur_start;
  logic [LEN_W-1:0] cur_len;
  logic sh_up;
  logic [IDX_W-1:0] sh_rd;
  logic [CNT_W-1:0] sh_left;

  // segment memory
  logic [ADDR_W-1:0] mem_start [MAX_SEGMENTS];
  logic [LEN_W-1:0] mem_len [MAX_SEGMENTS];
  logic rd_en, rd_vld, wr_en;
  logic [IDX_W-1:0] rd_addr, rd_idx, wr_addr;
  logic [ADDR_W-1:0] rd_start, wr_start;
  logic [LEN_W-1:0] rd_len, wr_len;
  logic rd_last;

  // decision logic
  logic [IDX_W-1:0] pick_idx, pos;
  logic [ADDR_W-1:0] pick_start, alloc_start;
  logic [LEN_W-1:0] pick_len, alloc_left, ext_len, merge_len;
  logic [ADDR_W+1:0] cur_end;
  logic merge_hit;

  assign req_ready = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign rd_last = rd_vld && ((CNT_W'(rd_idx) + CNT_W'(1)) == used);

  always_comb begin
    pick_idx = ex_f ? ex_idx : big_idx;
    pick_start = ex_f ? ex_start : big_start;
    pick_len = ex_f ? len_q : big_len;
    alloc_left = pick_len - len_q;
    alloc_start = pick_start + len_q[ADDR_W-1:0];
    ext_len = sat_add(end_len, len_q);
    pos = ins_f ? ins_idx : used[IDX_W-1:0];
    cur_end = {2'b00, cur_start} + {1'b0, cur_len};
    merge_len = sat_add(cur_len, rd_len);
    merge_hit = ({2'b00, rd_start} == cur_end);
  end

  // Select the read address
  always_comb begin
    rd_en = 1'b0;
    rd_addr = iss[IDX_W-1:0];
    case (state)
      S_SCAN, S_SUM: begin
        rd_en = (iss < used);
      end
      S_SHIFT: begin
        rd_en = (sh_left != '0);
        rd_addr = sh_rd;
      end
      S_MRD: begin
        rd_en = ((CNT_W'(cur) + CNT_W'(1)) < used);
        rd_addr = cur + IDX_W'(1);
      end
      default: rd_en = 1'b0;
    endcase
  end

  // Select the write port
  always_comb begin
    wr_en = 1'b0;
    wr_addr = cur;
    wr_start = cur_start;
    wr_len = cur_len;
    case (state)
      S_IDLE: begin
        if (req_valid && req.cmd == CMD_INIT && pool_size != '0) begin
          wr_en = 1'b1;
          wr_addr = '0;
          wr_start = pool_base;
          wr_len = pool_size;
        end
      end
      S_DECIDE: begin
        if (cmd_q == CMD_ALLOC && pick_len > len_q) begin
          wr_en = 1'b1;
          wr_addr = pick_idx;
          wr_start = alloc_start;
          wr_len = alloc_left;
        end else if (cmd_q == CMD_FREE && end_f) begin
          wr_en = 1'b1;
          wr_addr = end_idx;
          wr_start = end_start;
          wr_len = ext_len;
        end
      end
      S_SHIFT: begin
        wr_en = rd_vld;
        wr_addr = sh_up ? rd_idx + IDX_W'(1) : rd_idx - IDX_W'(1);
        wr_start = rd_start;
        wr_len = rd_len;
      end
      S_PUT: begin
        wr_en = 1'b1;
        wr_start = addr_q;
        wr_len = len_q;
      end
      S_MWAIT: begin
        wr_en = merge_hit;
        wr_len = merge_len;
      end
      default: wr_en = 1'b0;
    endcase
  end

  // Segment memory, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_start[wr_addr] <= wr_start;
      mem_len[wr_addr] <= wr_len;
    end
    if (rd_en) begin
      rd_start <= mem_start[rd_addr];
      rd_len <= mem_len[rd_addr];
    end
    rd_idx <= rd_addr;
    if (rst) begin
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= rd_en;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pool_base <= POOL_BASE_RST;
      pool_size <= POOL_SIZE_RST;
      used <= '0;
      free_sum <= '0;
      free_max <= '0;
      rsp_valid <= 1'b0;
      iss <= '0;
      ex_f <= 1'b0;
      end_f <= 1'b0;
      ins_f <= 1'b0;
      sh_up <= 1'b0;
      sh_left <= '0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == CFG_POOL_BASE) begin
          pool_base <= cfg_data[ADDR_W-1:0];
        end else begin
          pool_size <= cfg_data;
        end
      end
      if (rsp_valid && rsp_ready && state != S_FIN) begin
        rsp_valid <= 1'b0;
      end
      if (rd_en) begin
        iss <= iss + CNT_W'(1);
      end

      case (state)
        S_IDLE: begin
          if (req_valid) begin
            cmd_q <= req.cmd;
            len_q <= req.req_length;
            addr_q <= req.free_address;
            status_q <= ST_OK;
            grant_q <= '0;
            iss <= '0;
            ex_f <= 1'b0;
            end_f <= 1'b0;
            ins_f <= 1'b0;
            state <= S_FIN;
            case (req.cmd)
              CMD_ALLOC: begin
                if (used == '0 || req.req_length > free_max) begin
                  status_q <= ST_NOFIT;
                end else begin
                  state <= S_SCAN;
                end
              end
              CMD_FREE: begin
                if (req.req_length != '0) begin
                  state <= (used == '0) ? S_DECIDE : S_SCAN;
                end
              end
              CMD_INIT: begin
                used <= (pool_size != '0) ? CNT_W'(1) : '0;
                free_sum <= pool_size;
                free_max <= pool_size;
              end
              default: state <= S_FIN;
            endcase
          end
        end

        S_SCAN: begin
          if (rd_vld) begin
            if (!ex_f && rd_len == len_q) begin
              ex_f <= 1'b1;
              ex_idx <= rd_idx;
              ex_start <= rd_start;
            end
            if (rd_idx == '0 || rd_len > big_len) begin
              big_idx <= rd_idx;
              big_start <= rd_start;
              big_len <= rd_len;
            end
            if (!end_f && ({2'b00, rd_start} + {1'b0, rd_len}) == {2'b00, addr_q}) begin
              end_f <= 1'b1;
              end_idx <= rd_idx;
              end_start <= rd_start;
              end_len <= rd_len;
            end
            if (!ins_f && rd_start > addr_q) begin
              ins_f <= 1'b1;
              ins_idx <= rd_idx;
            end
            if (rd_last) begin
              state <= S_DECIDE;
            end
          end
        end

        S_DECIDE: begin
          iss <= '0;
          free_sum <= '0;
          free_max <= '0;
          if (cmd_q == CMD_ALLOC) begin
            if (pick_len < len_q) begin
              status_q <= ST_NOFIT;
              free_sum <= free_sum;
              free_max <= free_max;
              state <= S_FIN;
            end else begin
              grant_q <= pick_start;
              if (pick_len == len_q) begin
                sh_up <= 1'b0;
                sh_rd <= pick_idx + IDX_W'(1);
                sh_left <= used - CNT_W'(pick_idx) - CNT_W'(1);
                state <= S_SHIFT;
              end else begin
                state <= S_SUM;
              end
            end
          end else if (end_f) begin
            cur <= end_idx;
            cur_start <= end_start;
            cur_len <= ext_len;
            state <= S_MRD;
          end else if (used >= CNT_MAX) begin
            status_q <= ST_FULL;
            free_sum <= free_sum;
            free_max <= free_max;
            state <= S_FIN;
          end else begin
            cur <= pos;
            cur_start <= addr_q;
            cur_len <= len_q;
            sh_up <= 1'b1;
            sh_rd <= IDX_W'(used - CNT_W'(1));
            sh_left <= used - CNT_W'(pos);
            state <= S_SHIFT;
          end
        end

        // Move entries one place, read then write back
        S_SHIFT: begin
          if (sh_left != '0) begin
            sh_rd <= sh_up ? sh_rd - IDX_W'(1) : sh_rd + IDX_W'(1);
            sh_left <= sh_left - CNT_W'(1);
          end else if (!rd_vld) begin
            if (sh_up) begin
              state <= S_PUT;
            end else begin
              used <= used - CNT_W'(1);
              iss <= '0;
              free_sum <= '0;
              free_max <= '0;
              state <= S_SUM;
            end
          end
        end

        S_PUT: begin
          used <= used + CNT_W'(1);
          state <= S_MRD;
        end

        S_MRD: begin
          if (rd_en) begin
            state <= S_MWAIT;
          end else begin
            iss <= '0;
            free_sum <= '0;
            free_max <= '0;
            state <= S_SUM;
          end
        end

        // Merge with the following segment when adjacent
        S_MWAIT: begin
          if (merge_hit) begin
            sh_up <= 1'b0;
            sh_rd <= cur + IDX_W'(2);
            sh_left <= used - CNT_W'(cur) - CNT_W'(2);
            state <= S_SHIFT;
          end else begin
            iss <= '0;
            free_sum <= '0;
            free_max <= '0;
            state <= S_SUM;
          end
        end

        // Recount totals
        S_SUM: begin
          if (used == '0) begin
            state <= S_FIN;
          end else if (rd_vld) begin
            free_sum <= sat_add(free_sum, rd_len);
            if (rd_len > free_max) begin
              free_max <= rd_len;
            end
            if (rd_last) begin
              state <= S_FIN;
            end
          end
        end

        S_FIN: begin
          if (!rsp_valid || rsp_ready) begin
            rsp.status <= status_q;
            rsp.grant_address <= grant_q;
            rsp.total_free <= free_sum;
            rsp.largest_free <= free_max;
            rsp.segment_count <= CNT_OUT_W'(used);
            rsp_valid <= 1'b1;
            state <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  a_used_bound: assert property (@(posedge clk) disable iff (rst) used <= CNT_MAX)
    else $error("segment count above table depth");
  a_sum_ge_max: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> free_sum >= free_max)
    else $error("total free below largest free");
  a_empty_sum: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && used == '0) |-> free_sum == '0)
    else $error("empty table with nonzero total");
  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && status_q == ST_FULL) |-> used == CNT_MAX)
    else $error("table full reported while entries remain");

endmodule
